### rtl/binary_min_heap_queue_core_assert.svh
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core assertion macros
// Concurrent assertion shorthands sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types, sizes and codes of the binary min-heap priority queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_BITS    = 16;
  localparam int IN_KEY_W    = 16;
  localparam int TAG_W       = 8;
  localparam int COUNT_OUT_W = 7;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = CNT_W + 1;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CHILD_W-1:0]  child_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                action;
    logic [IN_KEY_W-1:0] key_in;
    tag_t                tag_in;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [IN_KEY_W-1:0]    key_out;
    tag_t                   tag_out;
    logic [IN_KEY_W-1:0]    min_key;
    tag_t                   min_tag;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_t;

  // Fit an input key into the stored key width.
  function automatic key_t key_from_in(logic [IN_KEY_W-1:0] k);
    logic [KEY_BITS+IN_KEY_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, k};
    return w[KEY_BITS-1:0];
  endfunction

  // Report the low bits of a stored key.
  function automatic logic [IN_KEY_W-1:0] key_to_out(key_t k);
    logic [KEY_BITS+IN_KEY_W-1:0] w;
    w = {{IN_KEY_W{1'b0}}, k};
    return w[IN_KEY_W-1:0];
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] count_to_out(cnt_t c);
    logic [CNT_W+COUNT_OUT_W-1:0] w;
    w = {{COUNT_OUT_W{1'b0}}, c};
    return w[COUNT_OUT_W-1:0];
  endfunction

  // Parent slot of a heap slot (slot must be nonzero).
  function automatic addr_t parent_of(addr_t p);
    addr_t m;
    m = p - addr_t'(1);
    return m >> 1;
  endfunction

endpackage

### rtl/binary_min_heap_queue_core.sv
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue of key/tag entries held in one RAM.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  in_t  : action, key_in, tag_in
//   out_     out  out_valid/out_stall out_t : status, key_out, tag_out,
//                                            min_key, min_tag, entry_count
//
// One transaction is worked at a time. An insert climbs one level per S_UP_CMP
// step until its parent key is not larger. An extract that removes the last
// entry goes straight to S_DONE; any other extract starts the last entry at the
// root and sifts it down: each level of the sift-down reads the left and then
// the right child through the single RAM read port. Refused operations (insert
// on full, extract on empty) also go straight to S_DONE. The next input can be
// accepted while out_valid is high.
// Reset clears the fill count and control; RAM contents are not cleared.
// The next input is accepted while a result waits in the output register;
// the sequencer holds its finished result until that register frees up.
// ---------------------------------------------------------------------------
module binary_min_heap_queue_core import bmhq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_RR,
    S_DN_CMP,
    S_PUT,
    S_DONE
  } state_t;

  state_t  state_r,     state_nxt;
  cnt_t    cnt_r,       cnt_nxt;
  addr_t   pos_r,       pos_nxt;
  entry_t  cur_r,       cur_nxt;    // entry being sifted, written only at its final slot
  entry_t  left_r,      left_nxt;   // left child captured during sift-down
  entry_t  root_r,      root_nxt;   // copy of slot 0, kept in step with every root write
  entry_t  kout_r,      kout_nxt;
  status_t status_r,    status_nxt;
  logic    out_valid_r, out_valid_nxt;
  out_t    out_r,       out_nxt;

  // RAM port signals
  logic               ram_we;
  addr_t              ram_waddr;
  entry_t             ram_wentry;
  addr_t              ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] ram_wdata;
  entry_t             rd_entry;

  assign ram_wdata = ram_wentry;
  assign rd_entry  = entry_t'(ram_rdata);

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sift-down child arithmetic
  child_t cnt_ext;
  child_t right_idx;
  child_t pick_idx;
  addr_t  pick_addr;
  logic   pick_right;
  entry_t pick_entry;
  addr_t  up_addr;

  assign cnt_ext    = {1'b0, cnt_r};
  assign right_idx  = child_t'({pos_r, 1'b1}) + child_t'(1);
  assign pick_right = (right_idx < cnt_ext) && (rd_entry.key <= left_r.key);
  assign pick_idx   = pick_right ? right_idx : child_t'({pos_r, 1'b1});
  assign pick_addr  = pick_idx[ADDR_W-1:0];
  assign pick_entry = pick_right ? rd_entry : left_r;
  assign up_addr    = parent_of(pos_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    kout_nxt      = kout_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wentry    = cur_r;
    ram_raddr     = '0;

    // Drop the held result once it is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Fetch the last entry for an extract, the parent of the free slot
        // for an insert; the data lands next cycle.
        if (in_data.action == ACT_EXTRACT) begin
          ram_raddr = addr_t'(cnt_r - cnt_t'(1));
        end else begin
          ram_raddr = parent_of(addr_t'(cnt_r));
        end
        if (in_valid) begin
          kout_nxt   = '0;
          status_nxt = ST_OK;
          if (in_data.action == ACT_INSERT) begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt.key = key_from_in(in_data.key_in);
              cur_nxt.tag = in_data.tag_in;
              pos_nxt     = addr_t'(cnt_r);
              cnt_nxt     = cnt_r + cnt_t'(1);
              state_nxt   = (cnt_r == '0) ? S_PUT : S_UP_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              kout_nxt  = root_r;
              cnt_nxt   = cnt_r - cnt_t'(1);
              state_nxt = (cnt_r == cnt_t'(1)) ? S_DONE : S_DN_LAST;
            end
          end
        end
      end

      S_UP_CMP: begin
        // rd_entry holds the parent of pos_r.
        if (rd_entry.key > cur_r.key) begin
          ram_we     = 1'b1;
          ram_wentry = rd_entry;
          pos_nxt    = up_addr;
          if (up_addr == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_raddr = parent_of(up_addr);
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DN_LAST: begin
        // rd_entry is the former last entry; it starts at the root.
        cur_nxt = rd_entry;
        pos_nxt = '0;
        if (cnt_r > cnt_t'(1)) begin
          ram_raddr = addr_t'(1);
          state_nxt = S_DN_RR;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wentry = rd_entry;
          state_nxt  = S_DONE;
        end
      end

      S_DN_RR: begin
        left_nxt  = rd_entry;
        ram_raddr = right_idx[ADDR_W-1:0];
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        // rd_entry holds the right child, valid only if it exists.
        if (pick_entry.key < cur_r.key) begin
          ram_we     = 1'b1;
          ram_wentry = pick_entry;
          pos_nxt    = pick_addr;
          if (child_t'({pick_addr, 1'b1}) < cnt_ext) begin
            ram_raddr = addr_t'({pick_addr, 1'b1});
            state_nxt = S_DN_RR;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.key_out     = key_to_out(kout_r.key);
          out_nxt.tag_out     = kout_r.tag;
          out_nxt.min_key     = (cnt_r != '0) ? key_to_out(root_r.key) : '0;
          out_nxt.min_tag     = (cnt_r != '0) ? root_r.tag : '0;
          out_nxt.entry_count = count_to_out(cnt_r);
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Keep the root copy coherent with RAM slot 0.
  always_comb begin
    root_nxt = root_r;
    if (ram_we && (ram_waddr == '0)) begin
      root_nxt = ram_wentry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    left_r   <= left_nxt;
    root_r   <= root_nxt;
    kout_r   <= kout_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule

### rtl/bmhq_ram.sv
// ---------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bmhq_checker.sv
// ---------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "binary_min_heap_queue_core_assert.svh"

module bmhq_checker import bmhq_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `BMHQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `BMHQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transaction taken while busy")
  `BMHQ_ASSERT_NOW(a_empty_report, out_valid && (out_data.status == ST_EMPTY), (out_data.entry_count == '0) && (out_data.key_out == '0) && (out_data.tag_out == '0) && (out_data.min_key == '0), "empty extract reported wrong fields")
  `BMHQ_ASSERT_NOW(a_full_report, out_valid && (out_data.status == ST_FULL), out_data.entry_count == COUNT_OUT_W'(CAPACITY), "full insert with count below capacity")

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (.*);

### verif/tb_binary_min_heap_queue_core.sv
// ---------------------------------------------------------------------------
// tb_binary_min_heap_queue_core
// Self-checking bench for the binary min-heap priority queue core: a short
// directed table, then random insert/extract phases that fill the heap,
// drain it and mix both. Each result is checked against a heap kept here.
// ---------------------------------------------------------------------------
module tb_binary_min_heap_queue_core;
  import bmhq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet stretch: sender gap, receiver stall and a full sift-down
  // all fit many times over in this many cycles.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to linger after the last result.
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned NUM_PHASES     = 6;

  typedef struct {
    in_t  op;
    bit   typed;   // expectation written by hand rather than predicted
    out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Heap kept by the bench, updated once per accepted transaction.
  entry_t      heap_slots [CAPACITY];
  int unsigned heap_fill;

  out_t        pending_results [$];
  plan_row_t   directed_plan [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          calm;    // no idling on either side

  binary_min_heap_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor: apply one operation to the local heap, return the result.
  // -------------------------------------------------------------------------
  function automatic out_t heap_apply(in_t op);
    out_t        r;
    entry_t      tmp;
    int unsigned pos;
    int unsigned up;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    r = '0;
    r.status = ST_OK;
    if (op.action == ACT_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_slots[heap_fill].key = key_t'(op.key_in);
        heap_slots[heap_fill].tag = op.tag_in;
        heap_fill++;
        // Climb while the parent key is strictly larger.
        pos = heap_fill - 1;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_slots[up].key > heap_slots[pos].key) begin
            tmp             = heap_slots[up];
            heap_slots[up]  = heap_slots[pos];
            heap_slots[pos] = tmp;
            pos             = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key_out = 16'(heap_slots[0].key);
        r.tag_out = heap_slots[0].tag;
        heap_fill--;
        if (heap_fill > 0) begin
          heap_slots[0] = heap_slots[heap_fill];
          // Sink: prefer the right child on a tie, take a lone left child.
          pos = 0;
          while (2 * pos + 1 < heap_fill) begin
            left  = 2 * pos + 1;
            right = left + 1;
            pick  = left;
            if (right < heap_fill && heap_slots[right].key <= heap_slots[left].key) begin
              pick = right;
            end
            if (heap_slots[pick].key < heap_slots[pos].key) begin
              tmp              = heap_slots[pick];
              heap_slots[pick] = heap_slots[pos];
              heap_slots[pos]  = tmp;
              pos              = pick;
            end else begin
              break;
            end
          end
        end
      end
    end
    if (heap_fill > 0) begin
      r.min_key = 16'(heap_slots[0].key);
      r.min_tag = heap_slots[0].tag;
    end
    r.entry_count = 7'(heap_fill);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic add_row(logic act, logic [15:0] k, tag_t t, bit typed = 1'b0,
                         status_t st = ST_OK, logic [15:0] ko = '0, tag_t to = '0,
                         logic [15:0] mk = '0, tag_t mt = '0, logic [6:0] cnt = '0);
    plan_row_t row;
    row.op.action         = act;
    row.op.key_in         = k;
    row.op.tag_in         = t;
    row.typed             = typed;
    row.want.status       = st;
    row.want.key_out      = ko;
    row.want.tag_out      = to;
    row.want.min_key      = mk;
    row.want.min_tag      = mt;
    row.want.entry_count  = cnt;
    directed_plan = {directed_plan, row};
  endtask

  // Present one transaction, hold it until accepted, then queue its result.
  // Valid is left high so a back-to-back transaction needs no second update.
  task automatic send_op(in_t op, bit typed, out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    // Always advance the local heap, even where the row carries its own answer.
    predicted = heap_apply(op);
    if (typed) begin
      predicted = want;
    end
    pending_results = {pending_results, predicted};
  endtask

  task automatic hold_off(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Result checker: pop the oldest expectation on every accepted result.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: %p", $realtime, out_data);
        end
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status",      exp_res.status,      out_data.status);
        check_field("key_out",     exp_res.key_out,     out_data.key_out);
        check_field("tag_out",     exp_res.tag_out,     out_data.tag_out);
        check_field("min_key",     exp_res.min_key,     out_data.min_key);
        check_field("min_tag",     exp_res.min_tag,     out_data.min_tag);
        check_field("entry_count", exp_res.entry_count, out_data.entry_count);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $realtime, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: alternate stall bursts and free-running stretches; stop stalling
  // once the run goes calm. One update per edge, so no glitch on out_stall.
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    in_t         op;
    out_t        no_want;
    int unsigned insert_pct [NUM_PHASES];
    bit          gappy;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    heap_fill    = 0;
    no_want      = '0;
    // Mixed, fill to full, drain to empty, and again.
    insert_pct   = '{50, 90, 10, 50, 90, 10};

    // Directed table. Hand-written answers only where they are obvious.
    // Extract on an empty heap right after reset is refused.
    add_row(ACT_EXTRACT, 16'h1234, 8'h5a, 1'b1, ST_EMPTY);
    // Largest and smallest key and tag.
    add_row(ACT_INSERT,  16'hffff, 8'hff, 1'b1, ST_OK, 16'h0, 8'h0, 16'hffff, 8'hff, 7'd1);
    add_row(ACT_INSERT,  16'h0000, 8'h00, 1'b1, ST_OK, 16'h0, 8'h0, 16'h0000, 8'h00, 7'd2);
    add_row(ACT_EXTRACT, 16'hffff, 8'hff, 1'b1, ST_OK, 16'h0, 8'h0, 16'hffff, 8'hff, 7'd1);
    add_row(ACT_EXTRACT, 16'h0000, 8'h00, 1'b1, ST_OK, 16'hffff, 8'hff, 16'h0, 8'h0, 7'd0);
    add_row(ACT_EXTRACT, 16'hffff, 8'hff, 1'b1, ST_EMPTY);
    // Lone left child after an extract: root 5 must sink below child 3.
    add_row(ACT_INSERT,  16'd1, 8'h11);
    add_row(ACT_INSERT,  16'd3, 8'h33);
    add_row(ACT_INSERT,  16'd5, 8'h55);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    // Equal keys: tie-break order shows in the tags.
    add_row(ACT_INSERT,  16'd7, 8'ha1);
    add_row(ACT_INSERT,  16'd7, 8'ha2);
    add_row(ACT_INSERT,  16'd7, 8'ha3);
    add_row(ACT_INSERT,  16'd7, 8'ha4);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    add_row(ACT_EXTRACT, 16'd0, 8'h00);
    // Alternating bit patterns; a full heap is reached in the random phases.
    add_row(ACT_INSERT,  16'haaaa, 8'h55);
    add_row(ACT_INSERT,  16'h5555, 8'haa);
    add_row(ACT_EXTRACT, 16'h0000, 8'h00);
    add_row(ACT_EXTRACT, 16'h0000, 8'h00);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      send_op(directed_plan[i].op, directed_plan[i].typed, directed_plan[i].want);
      if ($urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 11));
      end
    end

    // Random phases. Between phases, pause until every result is back.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      calm  = (ph == NUM_PHASES - 1);
      gappy = !calm && $urandom_range(0, 3) != 0;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        op.action = ($urandom_range(0, 99) < insert_pct[ph]) ? ACT_INSERT : ACT_EXTRACT;
        // Small keys force ties; extremes and full-range keys fill the rest.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op.key_in = 16'($urandom_range(0, 7));
          4:          op.key_in = 16'h0000;
          5:          op.key_in = 16'hffff;
          default:    op.key_in = 16'($urandom_range(0, 65535));
        endcase
        op.tag_in = 8'($urandom_range(0, 255));
        send_op(op, 1'b0, no_want);
        if (gappy && $urandom_range(0, 4) == 0) begin
          hold_off($urandom_range(1, 11));
        end
      end
      if (!calm) begin
        hold_off(1);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    // Drain: wait out every result, then linger for stray output.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_results.size());
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
